FILE: src/utf8_validate_and_count_top_macros.svh
// assertion macros for the utf8 validate and count block
`ifndef UTF8_VALIDATE_AND_COUNT_TOP_MACROS_SVH
`define UTF8_VALIDATE_AND_COUNT_TOP_MACROS_SVH

// implication checked outside reset
`define UTF8VC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utf8vc assertion failed");

// implication checked on the next cycle, outside reset
`define UTF8VC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utf8vc assertion failed");

// implication checked at every edge, reset included
`define UTF8VC_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("utf8vc assertion failed");

`endif

FILE: src/utf8vc_pkg.sv
// types and constants shared by the utf8 validate and count block
`default_nettype none
package utf8vc_pkg;

   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_LEAD  = 3'd1,
      ERR_CONT  = 3'd2,
      ERR_RANGE = 3'd3,
      ERR_TRUNC = 3'd4,
      ERR_LONG  = 3'd5
   } err_type;

   typedef enum logic [2:0] {
      RULE_NONE   = 3'd0,
      RULE_MIN_A0 = 3'd1,
      RULE_MAX_9F = 3'd2,
      RULE_MIN_90 = 3'd3,
      RULE_MAX_8F = 3'd4
   } rule_type;

   typedef struct packed {
      logic [1:0] pending;
      rule_type   rule;
      logic [7:0] count;
      err_type    err;
   } state_type;

   typedef struct packed {
      logic       is_valid;
      logic [7:0] code_points;
      err_type    error_kind;
   } result_type;

   localparam logic [7:0] MAX_CODE_POINTS_RESET = 8'd24;
   localparam logic [7:0] COUNT_MAX   = 8'hFF;
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_MIN   = 8'hC2;
   localparam logic [7:0] LEAD2_MAX   = 8'hDF;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD3_MAX   = 8'hEF;
   localparam logic [7:0] LEAD3_SURR  = 8'hED;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD4_MAX   = 8'hF4;
   localparam logic [1:0] CONT_TAG    = 2'b10;
   localparam logic [7:0] CONT_A0     = 8'hA0;
   localparam logic [7:0] CONT_9F     = 8'h9F;
   localparam logic [7:0] CONT_90     = 8'h90;
   localparam logic [7:0] CONT_8F     = 8'h8F;

endpackage
`default_nettype wire

FILE: src/utf8vc_if.sv
// channel interfaces of the utf8 validate and count block
`default_nettype none

interface utf8vc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_string;
   logic       no_byte;
   modport source (output valid, data_byte, end_of_string, no_byte, input ready);
   modport sink (input valid, data_byte, end_of_string, no_byte, output ready);
endinterface

interface utf8vc_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_valid;
   logic [7:0] code_points;
   logic [2:0] error_kind;
   modport source (output valid, is_valid, code_points, error_kind, input ready);
   modport sink (input valid, is_valid, code_points, error_kind, output ready);
endinterface

interface utf8vc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] max_code_points;
   modport source (output valid, max_code_points, input ready);
   modport sink (input valid, max_code_points, output ready);
endinterface

`default_nettype wire

FILE: src/utf8vc_step.sv
// per-byte decode: next string state and end-of-string verdict
`default_nettype none
module utf8vc_step
   import utf8vc_pkg::*;
(
   input  state_type  cur_state,
   input  logic [7:0] data_byte,
   input  logic       end_of_string,
   input  logic       no_byte,
   input  logic [7:0] max_code_points,
   output state_type  next_state,
   output result_type result
);

   state_type  upd;
   logic [7:0] count_inc;
   logic       range_bad;
   err_type    verdict;

   assign count_inc = (cur_state.count == COUNT_MAX) ? cur_state.count
                                                     : cur_state.count + 8'd1;

   always_comb begin
      case (cur_state.rule)
         RULE_MIN_A0: range_bad = (data_byte < CONT_A0);
         RULE_MAX_9F: range_bad = (data_byte > CONT_9F);
         RULE_MIN_90: range_bad = (data_byte < CONT_90);
         RULE_MAX_8F: range_bad = (data_byte > CONT_8F);
         default:     range_bad = 1'b0;
      endcase
   end

   always_comb begin
      upd = cur_state;
      if (!no_byte && (cur_state.err == ERR_NONE)) begin
         if (cur_state.pending == 2'd0) begin
            if (data_byte < ASCII_LIMIT) begin
               upd.count = count_inc;
            end else if ((data_byte >= LEAD2_MIN) && (data_byte <= LEAD2_MAX)) begin
               upd.pending = 2'd1;
               upd.rule    = RULE_NONE;
            end else if ((data_byte >= LEAD3_MIN) && (data_byte <= LEAD3_MAX)) begin
               upd.pending = 2'd2;
               if (data_byte == LEAD3_MIN) begin
                  upd.rule = RULE_MIN_A0;
               end else if (data_byte == LEAD3_SURR) begin
                  upd.rule = RULE_MAX_9F;
               end else begin
                  upd.rule = RULE_NONE;
               end
            end else if ((data_byte >= LEAD4_MIN) && (data_byte <= LEAD4_MAX)) begin
               upd.pending = 2'd3;
               if (data_byte == LEAD4_MIN) begin
                  upd.rule = RULE_MIN_90;
               end else if (data_byte == LEAD4_MAX) begin
                  upd.rule = RULE_MAX_8F;
               end else begin
                  upd.rule = RULE_NONE;
               end
            end else begin
               upd.err = ERR_LEAD;
            end
         end else if (data_byte[7:6] != CONT_TAG) begin
            upd.err = ERR_CONT;
         end else begin
            upd.rule = RULE_NONE;
            if (range_bad) begin
               upd.err = ERR_RANGE;
            end else begin
               upd.pending = cur_state.pending - 2'd1;
               if (cur_state.pending == 2'd1) begin
                  upd.count = count_inc;
               end
            end
         end
      end
   end

   always_comb begin
      verdict = upd.err;
      if ((verdict == ERR_NONE) && (upd.pending != 2'd0)) begin
         verdict = ERR_TRUNC;
      end
      if ((verdict == ERR_NONE) && (upd.count > max_code_points)) begin
         verdict = ERR_LONG;
      end
   end

   assign result.is_valid    = (verdict == ERR_NONE);
   assign result.code_points = upd.count;
   assign result.error_kind  = verdict;
   assign next_state         = end_of_string ? state_type'('0) : upd;

endmodule
`default_nettype wire

FILE: src/utf8vc_out_reg.sv
// result register driving the response channel
`default_nettype none
module utf8vc_out_reg
   import utf8vc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       free,
   utf8vc_rsp_if.source rsp_chan
);

   logic       valid_ff;
   result_type result_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
      if (free && load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.is_valid    = result_ff.is_valid;
   assign rsp_chan.code_points = result_ff.code_points;
   assign rsp_chan.error_kind  = result_ff.error_kind;

endmodule
`default_nettype wire

FILE: src/utf8_validate_and_count_top.sv
// top level of the strict utf8 validator and code point counter
// Takes one string byte per req transaction (none when no_byte is set) and
// returns one rsp transaction per string, on the item that has end_of_string
// set. Throughput is one byte per clock cycle while req is not stalled: the
// byte sits in an input register, is decoded by one level of compare logic
// against the per-string state, and the verdict of a final byte lands in the
// result register that drives rsp. Input and result registers are parted, so
// bytes keep flowing while a result waits; req stalls only when a finished
// result is still held and the next end-of-string item needs the result
// register. The character limit is written through the csr channel, which is
// always ready, and must only change while no string is in flight.
`default_nettype none
module utf8_validate_and_count_top
   import utf8vc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   utf8vc_req_if.sink   req_chan,
   utf8vc_rsp_if.source rsp_chan,
   utf8vc_csr_if.sink   csr_chan
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   logic       in_nob_ff;
   logic [7:0] max_cp_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type step_result;
   logic       out_free;
   logic       advance;
   logic       req_take;

   assign advance  = in_valid_ff && (!in_eos_ff || out_free);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
         max_cp_ff   <= MAX_CODE_POINTS_RESET;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_chan.valid) begin
            max_cp_ff <= csr_chan.max_code_points;
         end
      end
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_eos_ff  <= req_chan.end_of_string;
         in_nob_ff  <= req_chan.no_byte;
      end
   end

   utf8vc_step u_step (
      .cur_state       (state_ff),
      .data_byte       (in_byte_ff),
      .end_of_string   (in_eos_ff),
      .no_byte         (in_nob_ff),
      .max_code_points (max_cp_ff),
      .next_state      (state_in),
      .result          (step_result)
   );

   utf8vc_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && in_eos_ff),
      .result   (step_result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

FILE: src/utf8vc_checker.sv
// port-level assertions for the utf8 validate and count block
`default_nettype none
`include "utf8_validate_and_count_top_macros.svh"
module utf8vc_checker
   import utf8vc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_valid,
   input logic [7:0] rsp_code_points,
   input logic [2:0] rsp_error_kind
);

   `UTF8VC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_is_valid) && $stable(rsp_code_points) && $stable(rsp_error_kind))
   `UTF8VC_ASSERT_IMPL(a_verdict_matches_kind, rsp_valid, rsp_is_valid == (rsp_error_kind == ERR_NONE))
   `UTF8VC_ASSERT_IMPL(a_kind_known, rsp_valid, rsp_error_kind <= ERR_LONG)
   `UTF8VC_ASSERT_ALWAYS(a_reset_clears, $past(reset) && !reset, !rsp_valid)

endmodule

bind utf8_validate_and_count_top utf8vc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_is_valid    (rsp_chan.is_valid),
   .rsp_code_points (rsp_chan.code_points),
   .rsp_error_kind  (rsp_chan.error_kind)
);
`default_nettype wire
